[hdl/thmr_pkg.sv]
// Shared types, command codes and defaults for the two-hop route finder.
package thmr_pkg;

    localparam int MAX_ROUTES_DEF = 16;
    localparam int NODE_BITS_DEF  = 8;

    localparam int NODE_FIELD_W = 8;
    localparam int PROB_W       = 16;
    localparam int IN_DATA_W    = 56;
    localparam int OUT_DATA_W   = 32;

    localparam logic [PROB_W-1:0] PROB_ONE = 16'd32768;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_ADD   = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    localparam logic [1:0] HOPS_NONE   = 2'd0;
    localparam logic [1:0] HOPS_DIRECT = 2'd1;
    localparam logic [1:0] HOPS_TWO    = 2'd2;

    typedef struct packed {
        logic                    go;
        logic [NODE_FIELD_W-1:0] start_node;
        logic [NODE_FIELD_W-1:0] end_node;
    } thmr_req_t;

    typedef struct packed {
        logic busy;
        logic res_valid;
    } thmr_stat_t;

    typedef struct packed {
        logic [PROB_W-1:0]       best_probability;
        logic [1:0]              hop_count;
        logic [NODE_FIELD_W-1:0] via_node;
    } thmr_res_t;

endpackage

[hdl/thmr_mem.sv]
// Route table memory with one write port and one registered read port.
module thmr_mem
    import thmr_pkg::*;
#(
    parameter int DEPTH = MAX_ROUTES_DEF,
    parameter int WIDTH = 2 * NODE_BITS_DEF + PROB_W
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/thmr_scan.sv]
// Query sequencer: scans route pairs through the memory read port and keeps the best.
module thmr_scan
    import thmr_pkg::*;
#(
    parameter int MAX_ROUTES = MAX_ROUTES_DEF,
    parameter int NODE_BITS  = NODE_BITS_DEF
)
(
    input  logic                                                  clk,
    input  logic                                                  rst_n,
    input  thmr_req_t                                             req,
    input  logic [$clog2(MAX_ROUTES+1)-1:0]                       count,
    input  logic [2*((NODE_BITS < 8) ? NODE_BITS : 8)+PROB_W-1:0] rd_data,
    output logic                                                  rd_en,
    output logic [$clog2(MAX_ROUTES)-1:0]                         rd_addr,
    output thmr_stat_t                                            stat,
    output thmr_res_t                                             res,
    input  logic                                                  res_take
);

    localparam int AW = $clog2(MAX_ROUTES);
    localparam int CW = $clog2(MAX_ROUTES + 1);
    localparam int NW = (NODE_BITS < NODE_FIELD_W) ? NODE_BITS : NODE_FIELD_W;
    localparam int PW = 2 * PROB_W;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_OUTER  = 3'd1;
    localparam logic [2:0] ST_WAIT_A = 3'd2;
    localparam logic [2:0] ST_INNER  = 3'd3;
    localparam logic [2:0] ST_DRAIN  = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    logic [2:0]              st_reg, st_next;
    logic [AW-1:0]           i_reg, i_next;
    logic [AW-1:0]           j_reg, j_next;
    logic [NW-1:0]           start_reg, end_reg;
    logic [NW-1:0]           a_dst_reg;
    logic [PROB_W-1:0]       a_prob_reg;
    logic                    rd_vld_reg;
    logic                    rd_kind_reg;
    logic                    rd_kind;
    logic                    s1_vld_reg;
    logic [PW-1:0]           s1_prod_reg;
    logic [1:0]              s1_hops_reg;
    logic [NODE_FIELD_W-1:0] s1_via_reg;
    logic [PROB_W-1:0]       best_reg;
    logic [1:0]              hops_reg;
    logic [NODE_FIELD_W-1:0] via_reg;

    logic [NW-1:0]     rd_src, rd_dst;
    logic [PROB_W-1:0] rd_prob, s1_val;
    logic [CW-1:0]     count_m1;
    logic              last_i, last_j, direct_hit, pair_hit;

    assign rd_src   = rd_data[NW-1:0];
    assign rd_dst   = rd_data[2*NW-1:NW];
    assign rd_prob  = rd_data[2*NW+PROB_W-1:2*NW];
    assign count_m1 = count - CW'(1);
    assign last_i   = (CW'(i_reg) == count_m1);
    assign last_j   = (CW'(j_reg) == count_m1);
    assign s1_val   = s1_prod_reg[PROB_W+14:15];

    assign direct_hit = (st_reg == ST_WAIT_A) && (rd_src == start_reg) && (rd_dst == end_reg);
    assign pair_hit   = rd_vld_reg && rd_kind_reg && (rd_src == a_dst_reg)
                        && (rd_dst == end_reg);

    always_comb
    begin
        st_next = st_reg;
        i_next  = i_reg;
        j_next  = j_reg;
        rd_en   = 1'b0;
        rd_addr = i_reg;
        rd_kind = 1'b0;
        unique case (st_reg)
            ST_IDLE:
            begin
                if (req.go)
                begin
                    i_next  = '0;
                    st_next = (count == '0) ? ST_DRAIN : ST_OUTER;
                end
            end
            ST_OUTER:
            begin
                rd_en   = 1'b1;
                st_next = ST_WAIT_A;
            end
            ST_WAIT_A:
            begin
                if (rd_src == start_reg)
                begin
                    j_next  = '0;
                    st_next = ST_INNER;
                end
                else if (last_i)
                begin
                    st_next = ST_DRAIN;
                end
                else
                begin
                    i_next  = i_reg + AW'(1);
                    st_next = ST_OUTER;
                end
            end
            ST_INNER:
            begin
                rd_en   = 1'b1;
                rd_addr = j_reg;
                rd_kind = 1'b1;
                if (!last_j)
                begin
                    j_next = j_reg + AW'(1);
                end
                else if (last_i)
                begin
                    st_next = ST_DRAIN;
                end
                else
                begin
                    i_next  = i_reg + AW'(1);
                    st_next = ST_OUTER;
                end
            end
            ST_DRAIN:
            begin
                if (!rd_vld_reg && !s1_vld_reg)
                begin
                    st_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (res_take)
                begin
                    st_next = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= ST_IDLE;
            rd_vld_reg  <= 1'b0;
            s1_vld_reg  <= 1'b0;
            i_reg       <= '0;
            j_reg       <= '0;
        end
        else
        begin
            st_reg     <= st_next;
            rd_vld_reg <= rd_en;
            s1_vld_reg <= direct_hit || pair_hit;
            i_reg      <= i_next;
            j_reg      <= j_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_kind_reg <= rd_kind;
        if (st_reg == ST_IDLE && req.go)
        begin
            start_reg <= req.start_node[NW-1:0];
            end_reg   <= req.end_node[NW-1:0];
        end
        if (st_reg == ST_WAIT_A)
        begin
            a_dst_reg  <= rd_dst;
            a_prob_reg <= rd_prob;
        end
        if (direct_hit)
        begin
            s1_prod_reg <= {1'b0, rd_prob, 15'b0};
            s1_hops_reg <= HOPS_DIRECT;
            s1_via_reg  <= '0;
        end
        else
        begin
            s1_prod_reg <= a_prob_reg * rd_prob;
            s1_hops_reg <= HOPS_TWO;
            s1_via_reg  <= NODE_FIELD_W'(a_dst_reg);
        end
        if (st_reg == ST_IDLE && req.go)
        begin
            best_reg <= '0;
            hops_reg <= HOPS_NONE;
            via_reg  <= '0;
        end
        else if (s1_vld_reg && (s1_val > best_reg))
        begin
            best_reg <= s1_val;
            hops_reg <= s1_hops_reg;
            via_reg  <= s1_via_reg;
        end
    end

    assign stat.busy            = (st_reg != ST_IDLE);
    assign stat.res_valid       = (st_reg == ST_DONE);
    assign res.best_probability = best_reg;
    assign res.hop_count        = hops_reg;
    assign res.via_node         = via_reg;

endmodule

[hdl/two_hop_max_reliability_route.sv]
// Top level of the two-hop most-reliable-route finder with stream ports.
// Clear and add transactions do not hold the input; only a query returns a result.
// A query holds the input while it scans the stored routes, those leaving the start node
// and each route paired with them, through the single read port of the route memory.
// The result sits in an output register, so a new transaction is taken while it waits.
// Reset (rst_n, asynchronous, active low) empties the table and clears the overflow flag.
module two_hop_max_reliability_route
    import thmr_pkg::*;
#(
    parameter int MAX_ROUTES = MAX_ROUTES_DEF,
    parameter int NODE_BITS  = NODE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // Fields from bit 0: command, from_node, to_node, probability, start_node, end_node.
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // Fields from bit 0: best_probability, found, hop_count, via_node, table_overflowed.
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int AW = $clog2(MAX_ROUTES);
    localparam int CW = $clog2(MAX_ROUTES + 1);
    localparam int NW = (NODE_BITS < NODE_FIELD_W) ? NODE_BITS : NODE_FIELD_W;
    localparam int EW = 2 * NW + PROB_W;

    logic [1:0]              cmd;
    logic [NODE_FIELD_W-1:0] from_node, to_node, start_node, end_node;
    logic [PROB_W-1:0]       probability, prob_sat;

    logic [CW-1:0]         count_reg, count_next;
    logic                  ovf_reg, ovf_next;
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    logic          in_acc, wr_en, rd_en, res_take, full, query_go;
    logic [AW-1:0] rd_addr;
    logic [EW-1:0] wr_data, rd_data;
    thmr_req_t     req;
    thmr_stat_t    stat;
    thmr_res_t     res;

    assign cmd         = s_axis_tdata[1:0];
    assign from_node   = s_axis_tdata[9:2];
    assign to_node     = s_axis_tdata[17:10];
    assign probability = s_axis_tdata[33:18];
    assign start_node  = s_axis_tdata[41:34];
    assign end_node    = s_axis_tdata[49:42];

    assign s_axis_tready = !stat.busy;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign full          = (count_reg == CW'(MAX_ROUTES));
    assign prob_sat      = (probability > PROB_ONE) ? PROB_ONE : probability;
    assign wr_data       = {prob_sat, to_node[NW-1:0], from_node[NW-1:0]};

    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        wr_en      = 1'b0;
        query_go   = 1'b0;
        if (in_acc)
        begin
            unique case (cmd)
                CMD_CLEAR:
                begin
                    count_next = '0;
                    ovf_next   = 1'b0;
                end
                CMD_ADD:
                begin
                    if (full)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                end
                CMD_QUERY:
                begin
                    query_go = 1'b1;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    assign req.go         = query_go;
    assign req.start_node = start_node;
    assign req.end_node   = end_node;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    thmr_mem #(
        .DEPTH (MAX_ROUTES),
        .WIDTH (EW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    thmr_scan #(
        .MAX_ROUTES (MAX_ROUTES),
        .NODE_BITS  (NODE_BITS)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .count    (count_reg),
        .rd_data  (rd_data),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .stat     (stat),
        .res      (res),
        .res_take (res_take)
    );

    assign res_take = stat.res_valid && (!out_valid_reg || m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_data_reg <= {4'b0, ovf_reg, res.via_node, res.hop_count,
                             (res.best_probability != '0), res.best_probability};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

[hdl/thmr_check.sv]
// Port-level checker for the route finder result stream, bound to the top level.
module thmr_check
    import thmr_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("Result transaction changed while stalled.");

    a_found: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[16] == (m_axis_tdata[15:0] != 16'd0))
        else $error("Found flag disagrees with best probability.");

    a_none: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[16]
        |-> m_axis_tdata[18:17] == HOPS_NONE && m_axis_tdata[26:19] == 8'd0)
        else $error("Empty result carries a route.");

    a_hops: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[16]
        |-> (m_axis_tdata[18:17] == HOPS_DIRECT && m_axis_tdata[26:19] == 8'd0)
            || m_axis_tdata[18:17] == HOPS_TWO)
        else $error("Found result has a bad hop count or middle node.");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[15:0] <= PROB_ONE && m_axis_tdata[31:28] == 4'd0)
        else $error("Best probability above one or padding set.");

endmodule

bind two_hop_max_reliability_route thmr_check u_thmr_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

[sim/two_hop_max_reliability_route_test.sv]
// Self-checking testbench for the two-hop most-reliable-route finder with stream ports.
`timescale 1ns / 100ps

module two_hop_max_reliability_route_test;
    import thmr_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int TABLE_DEPTH = MAX_ROUTES_DEF;
    localparam int DRAIN_CYCLES = 400;

    typedef struct {
        logic [7:0]  src;
        logic [7:0]  dst;
        logic [15:0] prob;
    } route_t;

    typedef struct {
        logic [15:0] best;
        logic        found;
        logic [1:0]  hops;
        logic [7:0]  via;
        logic        overflowed;
    } route_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // Fields from bit 0: command, from_node, to_node, probability, start_node, end_node.
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // Fields from bit 0: best_probability, found, hop_count, via_node, table_overflowed.
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    route_t        routes [TABLE_DEPTH];
    int unsigned   route_total;
    logic          drop_flag;
    route_result_t pending_results [$];

    int sender_idle_pct;
    int receiver_idle_pct;
    int mismatch_count;
    int items_sent;
    int results_checked;
    int direct_wins;
    int two_hop_wins;
    int empty_answers;
    int overflow_answers;

    two_hop_max_reliability_route dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
        begin
            report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
        end
    endtask

    function automatic route_result_t find_best_route(input logic [7:0] start_node,
                                                       input logic [7:0] end_node);
        route_result_t res;
        logic [31:0]   prod;
        res.best = '0;
        res.hops = HOPS_NONE;
        res.via = '0;
        for (int i = 0; i < route_total; i++)
        begin
            if (routes[i].src == start_node)
            begin
                if (routes[i].dst == end_node && routes[i].prob > res.best)
                begin
                    res.best = routes[i].prob;
                    res.hops = HOPS_DIRECT;
                    res.via = '0;
                end
                for (int j = 0; j < route_total; j++)
                begin
                    if (routes[j].src == routes[i].dst && routes[j].dst == end_node)
                    begin
                        prod = (32'(routes[i].prob) * 32'(routes[j].prob)) >> 15;
                        if (prod > 32'(res.best))
                        begin
                            res.best = prod[15:0];
                            res.hops = HOPS_TWO;
                            res.via = routes[i].dst;
                        end
                    end
                end
            end
        end
        res.found = (res.best != 0);
        res.overflowed = drop_flag;
        return res;
    endfunction

    function automatic void update_route_table(input logic [IN_DATA_W-1:0] item);
        logic [1:0]    cmd;
        logic [15:0]   prob;
        route_result_t res;
        cmd = item[1:0];
        prob = item[33:18];
        case (cmd)
            CMD_CLEAR:
            begin
                route_total = 0;
                drop_flag = 1'b0;
            end
            CMD_ADD:
            begin
                if (route_total >= TABLE_DEPTH)
                begin
                    drop_flag = 1'b1;
                end
                else
                begin
                    routes[route_total].src = item[9:2];
                    routes[route_total].dst = item[17:10];
                    routes[route_total].prob = (prob > PROB_ONE) ? PROB_ONE : prob;
                    route_total++;
                end
            end
            CMD_QUERY:
            begin
                res = find_best_route(item[41:34], item[49:42]);
                case (res.hops)
                    HOPS_DIRECT: direct_wins++;
                    HOPS_TWO:    two_hop_wins++;
                    default:     empty_answers++;
                endcase
                if (res.overflowed)
                begin
                    overflow_answers++;
                end
                pending_results.insert(pending_results.size(), res);
            end
            default:
            begin
            end
        endcase
    endfunction

    // Called at a rising edge; returns at the edge where the transaction is accepted.
    task automatic send_item(input logic [1:0] cmd, input logic [7:0] from_node,
                             input logic [7:0] to_node, input logic [15:0] prob,
                             input logic [7:0] start_node, input logic [7:0] end_node);
        logic [IN_DATA_W-1:0] item;
        item = {6'b0, end_node, start_node, prob, to_node, from_node, cmd};
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= item;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        update_route_table(item);
        items_sent++;
    endtask

    task automatic add_route(input logic [7:0] from_node, input logic [7:0] to_node,
                             input logic [15:0] prob);
        send_item(CMD_ADD, from_node, to_node, prob, 8'($urandom), 8'($urandom));
    endtask

    task automatic query_route(input logic [7:0] start_node, input logic [7:0] end_node);
        send_item(CMD_QUERY, 8'($urandom), 8'($urandom), 16'($urandom), start_node, end_node);
    endtask

    task automatic clear_table();
        send_item(CMD_CLEAR, 8'($urandom), 8'($urandom), 16'($urandom), 8'($urandom),
                  8'($urandom));
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending_results.size() != 0);
    endtask

    function automatic logic [15:0] pick_probability(input logic [15:0] prev);
        case ($urandom_range(9))
            0:       return 16'd0;
            1:       return PROB_ONE;
            2:       return 16'($urandom_range(32769, 65535));
            3:       return prev;
            default: return 16'($urandom_range(1, 32768));
        endcase
    endfunction

    task automatic test_empty_and_ignored();
        query_route(8'd0, 8'd255);
        send_item(CMD_UNUSED, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF);
    endtask

    // The saturated direct route is found first; the equal two-hop product must not replace it.
    task automatic test_direct_and_saturation();
        add_route(8'd0, 8'd255, 16'hFFFF);
        add_route(8'd0, 8'd7, 16'h8001);
        add_route(8'd7, 8'd255, 16'hFFFF);
        add_route(8'd0, 8'd255, 16'd16384);
        add_route(8'd255, 8'd0, 16'd0);
        query_route(8'd0, 8'd255);
        query_route(8'd255, 8'd0);
    endtask

    task automatic test_two_hop_and_ties();
        add_route(8'd10, 8'd11, 16'd30000);
        add_route(8'd11, 8'd12, 16'd30000);
        add_route(8'd10, 8'd12, 16'd20000);
        add_route(8'd10, 8'd13, PROB_ONE);
        add_route(8'd13, 8'd12, 16'd27465);
        query_route(8'd10, 8'd12);
    endtask

    task automatic test_overflow_and_clear();
        for (int k = 0; k < 7; k++)
        begin
            add_route(8'h55 + 8'(k), 8'hAA, 16'h5555);
        end
        query_route(8'd0, 8'd255);
        clear_table();
        query_route(8'd0, 8'd255);
    endtask

    task automatic test_random_networks(input int item_target, input int send_pct,
                                        input int recv_pct);
        int          sent;
        int          span;
        int          base;
        int          n_routes;
        int          n_queries;
        logic [15:0] last_prob;
        sender_idle_pct = send_pct;
        receiver_idle_pct = recv_pct;
        sent = 0;
        last_prob = PROB_ONE;
        wait_for_results();
        while (sent < item_target)
        begin
            if ($urandom_range(9) != 0)
            begin
                clear_table();
                sent++;
            end
            span = ($urandom_range(4) == 0) ? 255 : $urandom_range(1, 5);
            base = $urandom_range(255 - span);
            n_routes = ($urandom_range(3) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 10);
            repeat (n_routes)
            begin
                last_prob = pick_probability(last_prob);
                add_route(8'(base + $urandom_range(span)), 8'(base + $urandom_range(span)),
                          last_prob);
                sent++;
            end
            n_queries = $urandom_range(1, 6);
            repeat (n_queries)
            begin
                if ($urandom_range(19) == 0)
                begin
                    send_item(CMD_UNUSED, 8'($urandom), 8'($urandom), 16'($urandom),
                              8'($urandom), 8'($urandom));
                end
                query_route(8'(base + $urandom_range(span)), 8'(base + $urandom_range(span)));
                sent++;
            end
            if ($urandom_range(15) == 0)
            begin
                wait_for_results();
            end
        end
    endtask

    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    always @(posedge clk)
    begin
        route_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch($sformatf("result 0x%08h arrived with nothing pending",
                                          m_axis_tdata));
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("best_probability", int'(m_axis_tdata[15:0]), int'(want.best));
                check_field("found", int'(m_axis_tdata[16]), int'(want.found));
                check_field("hop_count", int'(m_axis_tdata[18:17]), int'(want.hops));
                check_field("via_node", int'(m_axis_tdata[26:19]), int'(want.via));
                check_field("table_overflowed", int'(m_axis_tdata[27]),
                            int'(want.overflowed));
                results_checked++;
            end
        end
    end

    initial
    begin
        #8_000_000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        int guard;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        sender_idle_pct = 34;
        receiver_idle_pct = 51;
        route_total = 0;
        drop_flag = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_and_ignored();
        test_direct_and_saturation();
        test_two_hop_and_ties();
        test_overflow_and_clear();
        test_random_networks(375, 34, 51);
        test_random_networks(375, 51, 34);
        test_random_networks(375, 0, 0);

        s_axis_tvalid <= 1'b0;
        guard = 0;
        while (pending_results.size() != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        end

        $display("Sent %0d transactions and checked %0d query results.", items_sent,
                 results_checked);
        $display("Answers: %0d direct, %0d two-hop, %0d empty, %0d with overflow set.",
                 direct_wins, two_hop_wins, empty_answers, overflow_answers);
        if (mismatch_count == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
